>>> sv/lpht_pkg.sv
package lpht_pkg;

    // defaults for the top-level parameters
    localparam int TABLE_SIZE_DEF = 256;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;

    // hash reduction: 32-bit hash folded into the remainder a byte per cycle
    localparam int HASH_W     = 32;
    localparam int MOD_STEP   = 8;
    localparam int MOD_CYCLES = HASH_W / MOD_STEP;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_FIND   = 2'd1;
    localparam t_cmd CMD_ERASE  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_UPDATED   = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_ERASED    = 3'd4;
    localparam t_status ST_FULL      = 3'd5;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] key_bytes;
        logic [31:0] entry_value;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
        logic [8:0]  occupancy;
    } t_rsp;

endpackage

>>> sv/lpht_if.sv
interface lpht_req_if import lpht_pkg::*;;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*;;
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/lpht_fifo.sv
module lpht_fifo import lpht_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CNW-1:0]   r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != CNW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> sv/lpht_front.sv
module lpht_front import lpht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = KEY_BYTES_DEF,
    localparam int IW = $clog2(TABLE_SIZE),
    localparam int KW = 8 * KEY_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output t_cmd          o_job_cmd,
    output logic [KW-1:0] o_job_key,
    output logic [31:0]   o_job_val,
    output logic [IW-1:0] o_job_home
);
    localparam int CNTW = $clog2(KEY_BYTES + 1);
    localparam int MCW  = $clog2(MOD_CYCLES);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [CNTW-1:0]  r_cnt;
    logic [MCW-1:0]   r_mcnt;
    t_cmd             r_cmd;
    logic [63:0]      r_key, r_shift, r_mask;
    logic [31:0]      r_val;
    logic [HASH_W-1:0] r_hash;
    logic [IW-1:0]    r_rem;

    logic [7:0]       w_byte;
    logic             w_key_end;
    logic [IW:0]      w_t;
    logic [63:0]      w_key_norm;

    assign w_byte     = r_shift[63:56];
    assign w_key_end  = (r_cnt == CNTW'(KEY_BYTES)) || (w_byte == 8'd0);
    assign w_key_norm = r_key & r_mask;

    // restoring remainder, one hash bit per step
    always_comb begin
        w_t = {1'b0, r_rem};
        for (int k = 0; k < MOD_STEP; k++) begin
            w_t = {w_t[IW-1:0], r_hash[HASH_W-1-k]};
            if (w_t >= (IW + 1)'(TABLE_SIZE)) begin
                w_t = w_t - (IW + 1)'(TABLE_SIZE);
            end
        end
    end

    assign o_req_ready = (r_state == F_IDLE) && !i_hold;
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job_cmd   = r_cmd;
    assign o_job_key   = w_key_norm[63 -: KW];
    assign o_job_val   = r_val;
    assign o_job_home  = r_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                if (w_key_end) begin
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                if (r_mcnt == MCW'(MOD_CYCLES - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE) begin
                r_cnt  <= '0;
                r_mcnt <= '0;
            end else if (r_state == F_HASH && !w_key_end) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == F_MOD) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_req_valid && o_req_ready) begin
            r_cmd   <= i_req.command;
            r_key   <= i_req.key_bytes;
            r_shift <= i_req.key_bytes;
            r_val   <= i_req.entry_value;
            r_mask  <= '0;
            r_hash  <= '0;
        end else if (r_state == F_HASH) begin
            if (w_key_end) begin
                r_rem <= '0;
            end else begin
                r_hash  <= (r_hash << 5) + r_hash + HASH_W'(w_byte);
                r_mask  <= {8'hFF, r_mask[63:8]};
                r_shift <= r_shift << 8;
            end
        end else if (r_state == F_MOD) begin
            r_rem  <= w_t[IW-1:0];
            r_hash <= r_hash << MOD_STEP;
        end
    end
endmodule

>>> sv/lpht_back.sv
module lpht_back import lpht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = KEY_BYTES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IW = $clog2(TABLE_SIZE),
    localparam int KW = 8 * KEY_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  t_cmd          i_job_cmd,
    input  logic [KW-1:0] i_job_key,
    input  logic [31:0]   i_job_val,
    input  logic [IW-1:0] i_job_home,
    output logic          o_clearing,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output t_rsp          o_rsp
);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int EW = 1 + KW + VALUE_BITS;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_CHECK = 4'b0100,
        B_OUT   = 4'b1000
    } t_bstate;

    // slot entry: occupied bit, key, value
    logic [EW-1:0] r_mem [TABLE_SIZE];
    logic [EW-1:0] r_rd;

    t_bstate       r_state, n_state;
    logic [IW-1:0] r_idx, n_idx, r_n, n_n, r_clr, n_clr;
    logic [CW-1:0] r_count, n_count;
    t_cmd          r_cmd;
    logic [KW-1:0] r_key;
    logic [31:0]   r_val;
    t_rsp          r_rsp, n_rsp;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr, w_idx_inc;
    logic [EW-1:0] wr_data;
    logic          w_rd_occ, w_last;
    logic [KW-1:0] w_rd_key;
    logic [VALUE_BITS-1:0] w_rd_val;

    assign w_rd_occ  = r_rd[EW-1];
    assign w_rd_key  = r_rd[VALUE_BITS +: KW];
    assign w_rd_val  = r_rd[VALUE_BITS-1:0];
    assign w_idx_inc = (r_idx == IW'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
    assign w_last    = (r_n == IW'(TABLE_SIZE - 1));

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_job_ready = (r_state == B_IDLE);
    assign o_rsp_valid = (r_state == B_OUT);
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_clr   = r_clr;
        n_count = r_count;
        n_rsp   = r_rsp;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        rd_addr = i_job_home;
        unique case (r_state)
            B_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IW'(TABLE_SIZE - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid) begin
                    n_idx = i_job_home;
                    n_n   = '0;
                    if (i_job_cmd == CMD_INSERT || i_job_cmd == CMD_FIND ||
                        i_job_cmd == CMD_ERASE) begin
                        n_state = B_CHECK;
                    end else begin
                        n_rsp.status      = ST_NOT_FOUND;
                        n_rsp.found_value = '0;
                        n_rsp.occupancy   = 9'(r_count);
                        n_state           = B_OUT;
                    end
                end
            end
            B_CHECK: begin
                // next slot is fetched ahead so a miss moves on without a wait state
                rd_addr           = w_idx_inc;
                n_rsp.found_value = '0;
                if (!w_rd_occ) begin
                    n_state = B_OUT;
                    if (r_cmd == CMD_INSERT) begin
                        wr_en        = 1'b1;
                        wr_data      = {1'b1, r_key, VALUE_BITS'(r_val)};
                        n_count      = r_count + 1'b1;
                        n_rsp.status = ST_INSERTED;
                    end else begin
                        n_rsp.status = ST_NOT_FOUND;
                    end
                end else if (w_rd_key == r_key) begin
                    n_state = B_OUT;
                    if (r_cmd == CMD_INSERT) begin
                        wr_en        = 1'b1;
                        wr_data      = {1'b1, r_key, VALUE_BITS'(r_val)};
                        n_rsp.status = ST_UPDATED;
                    end else if (r_cmd == CMD_FIND) begin
                        n_rsp.found_value = 32'(w_rd_val);
                        n_rsp.status      = ST_FOUND;
                    end else begin
                        wr_en        = 1'b1;
                        n_count      = (r_count != '0) ? r_count - 1'b1 : r_count;
                        n_rsp.status = ST_ERASED;
                    end
                end else if (w_last) begin
                    n_state      = B_OUT;
                    n_rsp.status = (r_cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    n_idx = w_idx_inc;
                    n_n   = r_n + 1'b1;
                end
                n_rsp.occupancy = 9'(n_count);
            end
            B_OUT: begin
                if (i_rsp_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
            r_n     <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            r_cmd <= i_job_cmd;
            r_key <= i_job_key;
            r_val <= i_job_val;
        end
        r_rsp <= n_rsp;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SIZE))
        else $error("occupancy above table size");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_job_ready)
        else $error("job taken during clearing pass");

    a_found_is_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_FOUND) |-> (r_cmd == CMD_FIND))
        else $error("found status on a non-find command");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHECK && n_state == B_OUT && n_rsp.status == ST_INSERTED)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise occupancy");
endmodule

>>> sv/linear_probe_hash_table.sv
// Hash table with linear probing, keys of up to eight bytes.
// i_req takes one command per transfer: insert, find or erase, with a key
// and a value. o_rsp returns exactly one result per command, in order:
// status, the found value and the slot occupancy after the command.
// The front hashes the key one byte per cycle up to the first zero byte
// or the last of KEY_BYTES bytes, then reduces the 32-bit hash modulo
// TABLE_SIZE a byte at a time and hands the job to a 2-entry queue.
// The back walks the slot memory one probe per cycle through its single
// read port: it reads the home slot as it takes the job, then probes at
// most TABLE_SIZE slots, and the result then sits in the output register.
// The front takes a new command only once it has handed its job to the
// queue, so front and back overlap through the queue.
// After reset the back clears the slot memory, one slot a cycle over all
// TABLE_SIZE slots; no command is taken until the pass ends.
// When the receiver stalls, the result holds in the output register and the
// front keeps taking commands until the queue is full.
module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_BYTES  = KEY_BYTES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp
);
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int KW = 8 * KEY_BYTES;
    localparam int JW = $bits(t_cmd) + KW + 32 + IW;

    logic          w_clearing;
    logic          f_valid, f_ready, b_valid, b_ready;
    t_cmd          f_cmd, b_cmd;
    logic [KW-1:0] f_key, b_key;
    logic [31:0]   f_val, b_val;
    logic [IW-1:0] f_home, b_home;
    logic [JW-1:0] w_push_data, w_pop_data;
    logic          w_rsp_valid;
    t_rsp          w_rsp;

    lpht_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_clearing),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (i_req.payload),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job_cmd   (f_cmd),
        .o_job_key   (f_key),
        .o_job_val   (f_val),
        .o_job_home  (f_home)
    );

    assign w_push_data = {f_cmd, f_key, f_val, f_home};

    lpht_fifo #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (w_pop_data)
    );

    assign {b_cmd, b_key, b_val, b_home} = w_pop_data;

    lpht_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .i_job_cmd   (b_cmd),
        .i_job_key   (b_key),
        .i_job_val   (b_val),
        .i_job_home  (b_home),
        .o_clearing  (w_clearing),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.valid   = w_rsp_valid;
    assign o_rsp.payload = w_rsp;
endmodule

>>> test/testbench.sv
module testbench;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // expected table contents, updated at every accepted command
    class hash_table_shadow;
        logic [63:0] slot_key [TABLE_SIZE_DEF];
        logic [31:0] slot_value [TABLE_SIZE_DEF];
        bit          slot_used [TABLE_SIZE_DEF];
        int          entry_count;
        int          peak_count;
        int          failures;
        int          commands_seen;
        int          results_seen;
        int          status_seen [6];
        t_rsp        pending_rsp [$];

        function new();
            for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
                slot_used[i] = 0;
            end
            entry_count = 0;
            peak_count = 0;
            failures = 0;
            commands_seen = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // walk the probe sequence and apply the command to the shadow table
        function t_rsp apply_command(t_req r);
            logic [63:0] key;
            logic [31:0] h;
            logic [7:0]  b;
            bit          ended;
            bit          done;
            int          idx;
            t_rsp        o;
            key = '0;
            h = '0;
            ended = 0;
            done = 0;
            for (int i = 0; i < KEY_BYTES_DEF; i++) begin
                b = r.key_bytes[63 - 8 * i -: 8];
                if (b == 8'd0) ended = 1;
                if (!ended) begin
                    key[63 - 8 * i -: 8] = b;
                    h = h * 33 + b;
                end
            end
            idx = int'(h % TABLE_SIZE_DEF);
            o.status = (r.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
            o.found_value = '0;
            if (r.command == CMD_INSERT || r.command == CMD_FIND || r.command == CMD_ERASE) begin
                for (int n = 0; n < TABLE_SIZE_DEF && !done; n++) begin
                    if (!slot_used[idx]) begin
                        if (r.command == CMD_INSERT) begin
                            slot_key[idx] = key;
                            slot_value[idx] = r.entry_value;
                            slot_used[idx] = 1;
                            entry_count++;
                            o.status = ST_INSERTED;
                        end
                        done = 1;
                    end else if (slot_key[idx] == key) begin
                        if (r.command == CMD_INSERT) begin
                            slot_value[idx] = r.entry_value;
                            o.status = ST_UPDATED;
                        end else if (r.command == CMD_FIND) begin
                            o.found_value = slot_value[idx];
                            o.status = ST_FOUND;
                        end else begin
                            slot_used[idx] = 0;
                            if (entry_count > 0) entry_count--;
                            o.status = ST_ERASED;
                        end
                        done = 1;
                    end
                    idx = (idx + 1) % TABLE_SIZE_DEF;
                end
            end
            o.occupancy = entry_count[8:0];
            if (entry_count > peak_count) peak_count = entry_count;
            return o;
        endfunction

        function void note_command(t_req r);
            commands_seen++;
            pending_rsp.push_back(apply_command(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            results_seen++;
            if (pending_rsp.size() == 0) begin
                $error("result with nothing outstanding: status %0d", got.status);
                failures++;
            end else begin
                want = pending_rsp.pop_front();
                if (want.status <= ST_FULL) status_seen[want.status]++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    failures++;
                end
                if (got.found_value !== want.found_value) begin
                    $error("found_value: expected %0h, actual %0h",
                           want.found_value, got.found_value);
                    failures++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           want.occupancy, got.occupancy);
                    failures++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lpht_req_if req_if ();
    lpht_rsp_if rsp_if ();

    linear_probe_hash_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    hash_table_shadow table_shadow = new();

    bit          send_burst;
    bit          recv_burst;
    bit          hold_off_pending;
    logic [63:0] key_pool [$];
    logic [63:0] fill_keys [$];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // two-byte key whose hash lands on the given home slot, garbage after the end
    function automatic logic [63:0] key_for_slot(int slot);
        int          x;
        int          y;
        logic [63:0] k;
        do begin
            x = $urandom_range(1, 255);
            y = (slot - 33 * x) & 255;
        end while (y == 0);
        k = {$urandom, $urandom};
        k[63:40] = {x[7:0], y[7:0], 8'h00};
        return k;
    endfunction

    function automatic logic [63:0] random_key(int min_len);
        int          len;
        logic [63:0] k;
        len = $urandom_range(min_len, 8);
        for (int i = 0; i < 8; i++) begin
            if (i < len) k[63 - 8 * i -: 8] = 8'($urandom_range(1, 255));
            else if (i == len) k[63 - 8 * i -: 8] = 8'h00;
            else k[63 - 8 * i -: 8] = 8'($urandom_range(0, 255));
        end
        return k;
    endfunction

    task automatic send_cmd(t_cmd c, logic [63:0] k, logic [31:0] v);
        int   gap;
        t_req r;
        r.command = c;
        r.key_bytes = k;
        r.entry_value = v;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        table_shadow.note_command(r);
    endtask

    task automatic send_random_cmd(logic [63:0] k);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) send_cmd(CMD_INSERT, k, $urandom);
        else if (pick < 75) send_cmd(CMD_FIND, k, $urandom);
        else if (pick < 95) send_cmd(CMD_ERASE, k, $urandom);
        else send_cmd(t_cmd'(3), k, $urandom);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            if (hold_off_pending) begin
                hold_off_pending = 0;
                stall = 400;
            end else begin
                stall = recv_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            table_shadow.check_result(rsp_if.payload);
        end
    end

    initial begin
        logic [63:0] wrap_k1;
        logic [63:0] wrap_k2;
        logic [63:0] wrap_k3;
        logic [63:0] k;
        int          guard;
        int          waited;

        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        rsp_if.ready <= 1'b0;
        send_burst = 0;
        recv_burst = 0;
        hold_off_pending = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty key with trailing garbage, then the same key all zero
        send_cmd(CMD_INSERT, 64'h00AB_CDEF_0123_4567, 32'h0000_0000);
        send_cmd(CMD_FIND, 64'h0, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send_cmd(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        // bytes after the terminator do not belong to the key
        send_cmd(CMD_INSERT, 64'h6162_00DE_ADBE_EF55, 32'hA5A5_5A5A);
        send_cmd(CMD_FIND, 64'h6162_0000_0000_0000, 32'h0);
        // chain that wraps from the last slot past the occupied slot zero
        wrap_k1 = key_for_slot(TABLE_SIZE_DEF - 1);
        do wrap_k2 = key_for_slot(TABLE_SIZE_DEF - 1); while (wrap_k2[63:48] == wrap_k1[63:48]);
        do wrap_k3 = key_for_slot(TABLE_SIZE_DEF - 1);
        while (wrap_k3[63:48] == wrap_k1[63:48] || wrap_k3[63:48] == wrap_k2[63:48]);
        send_cmd(CMD_INSERT, wrap_k1, $urandom);
        send_cmd(CMD_INSERT, wrap_k2, $urandom);
        send_cmd(CMD_INSERT, wrap_k3, $urandom);
        send_cmd(CMD_FIND, wrap_k3, $urandom);
        // erase in the middle breaks the chain to the third key
        send_cmd(CMD_ERASE, wrap_k2, $urandom);
        send_cmd(CMD_FIND, wrap_k3, $urandom);
        send_cmd(CMD_INSERT, wrap_k3, $urandom);
        send_cmd(CMD_ERASE, 64'h7A7A_7A00_0000_0000, $urandom);
        send_cmd(CMD_FIND, 64'h7A7A_7A00_0000_0000, $urandom);
        send_cmd(t_cmd'(3), 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ERASE, 64'h0, $urandom);
        send_cmd(CMD_FIND, 64'h0, $urandom);

        // mixed traffic over a pool of keys, many sharing home slots
        for (int i = 0; i < 16; i++) key_pool.push_back(random_key(0));
        for (int i = 0; i < 24; i++) key_pool.push_back(key_for_slot((i % 4 < 2) ? 3 + i % 2 : 100));
        for (int i = 0; i < 250; i++) begin
            if (i == 100) hold_off_pending = 1;
            if ($urandom_range(0, 9) == 0) k = random_key(0);
            else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_random_cmd(k);
        end

        // fill the table to the last slot
        guard = 0;
        while (table_shadow.entry_count < TABLE_SIZE_DEF && guard < 400) begin
            guard++;
            if (guard % 8 == 0) begin
                send_cmd(CMD_FIND, key_pool[$urandom_range(0, key_pool.size() - 1)], $urandom);
            end else begin
                k = random_key(3);
                fill_keys.push_back(k);
                send_cmd(CMD_INSERT, k, $urandom);
            end
        end
        // full table: new keys are refused, lookups and erases walk every slot, known keys update
        for (int i = 0; i < 6; i++) send_cmd(CMD_INSERT, random_key(3), $urandom);
        for (int i = 0; i < 6; i++) send_cmd(CMD_FIND, random_key(3), $urandom);
        for (int i = 0; i < 4; i++) send_cmd(CMD_ERASE, random_key(3), $urandom);
        for (int i = 0; i < 6; i++) begin
            send_cmd(CMD_INSERT, fill_keys[$urandom_range(0, fill_keys.size() - 1)], $urandom);
        end
        // drain part of it again and mix finds over the holes
        for (int i = 0; i < 40; i++) begin
            k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
            if (i % 3 == 2) send_cmd(CMD_INSERT, random_key(3), $urandom);
            else send_random_cmd(k);
        end

        req_if.valid <= 1'b0;
        waited = 0;
        while (table_shadow.pending_rsp.size() > 0 && waited < 100_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TABLE_SIZE_DEF + 40) @(posedge i_clk);
        if (table_shadow.pending_rsp.size() > 0) begin
            $error("%0d results never arrived", table_shadow.pending_rsp.size());
            table_shadow.failures++;
        end

        $display("run covered %0d commands and %0d results, peak occupancy %0d of %0d",
                 table_shadow.commands_seen, table_shadow.results_seen,
                 table_shadow.peak_count, TABLE_SIZE_DEF);
        $display("statuses: %0d inserted, %0d updated, %0d found, %0d not found, %0d erased, %0d full",
                 table_shadow.status_seen[ST_INSERTED], table_shadow.status_seen[ST_UPDATED],
                 table_shadow.status_seen[ST_FOUND], table_shadow.status_seen[ST_NOT_FOUND],
                 table_shadow.status_seen[ST_ERASED], table_shadow.status_seen[ST_FULL]);
        if (table_shadow.failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> linear_probe_hash_table.f
sv/lpht_pkg.sv
sv/lpht_if.sv
sv/lpht_fifo.sv
sv/lpht_front.sv
sv/lpht_back.sv
sv/linear_probe_hash_table.sv
test/testbench.sv
